>>> rtl/sma_pkg.sv
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants for the stack machine ALU: opcodes, status codes,
// the input and result words, and the request/response of the mul/div unit.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int DataW          = 32;
  localparam int CmdW           = 3;
  localparam int StatusW        = 3;
  localparam int StackDepthDef  = 256;

  typedef enum logic [CmdW-1:0] {
    CMD_RET  = 3'd0,
    CMD_PUSH = 3'd1,
    CMD_POP  = 3'd2,
    CMD_ADD  = 3'd3,
    CMD_SUB  = 3'd4,
    CMD_MUL  = 3'd5,
    CMD_DIV  = 3'd6
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 3'd0,
    ST_RET   = 3'd1,
    ST_UNDER = 3'd2,
    ST_OVER  = 3'd3,
    ST_DIVZ  = 3'd4
  } status_e;

  typedef struct packed {
    logic [CmdW-1:0]         cmd;
    logic signed [DataW-1:0] push_value;
  } sma_in_t;

  typedef struct packed {
    logic                    printed;
    logic signed [DataW-1:0] out_value;
    logic [StatusW-1:0]      status;
  } sma_out_t;

  // Request to the iterative multiply/divide unit.
  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [DataW-1:0] a;   // top of stack
    logic [DataW-1:0] b;   // next entry
  } md_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } md_rsp_t;

endpackage

>>> rtl/sma_ram.sv
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 256,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/sma_muldiv.sv
// ----------------------------------------------------------------------------
// sma_muldiv
// Iterative multiply/divide on one shared 34-bit adder, one result bit per
// cycle. Multiply keeps the low 32 bits; divide truncates toward zero.
// ----------------------------------------------------------------------------
module sma_muldiv (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sma_pkg::md_req_t req_i,
  output sma_pkg::md_rsp_t rsp_o
);
  import sma_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE,
    M_ABS_A,
    M_ABS_B,
    M_STEP,
    M_FIX
  } md_state_e;

  localparam int CntW = $clog2(DataW);

  md_state_e        state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             is_div_q, is_div_d;
  logic             neg_q, neg_d;
  logic [DataW-1:0] acc_q, acc_d;   // mul: partial product, div: remainder
  logic [DataW-1:0] sh_q, sh_d;     // mul: multiplicand, div: dividend/quotient
  logic [DataW-1:0] m_q, m_d;       // mul: multiplier, div: divisor

  // Shared adder.
  logic [DataW+1:0] add_x, add_y, sum;
  logic             add_cin;
  logic [DataW:0]   rem_sh;
  logic             ge;

  assign rem_sh = {acc_q, sh_q[DataW-1]};
  assign sum    = add_x + add_y + {{(DataW+1){1'b0}}, add_cin};
  assign ge     = ~sum[DataW+1];

  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_cin = 1'b0;
    unique case (state_q)
      M_ABS_A, M_FIX: begin
        add_x   = {2'b00, ~sh_q};
        add_cin = 1'b1;
      end
      M_ABS_B: begin
        add_x   = {2'b00, ~m_q};
        add_cin = 1'b1;
      end
      M_STEP: begin
        if (is_div_q) begin
          add_x   = {1'b0, rem_sh};
          add_y   = ~{2'b00, m_q};
          add_cin = 1'b1;
        end else begin
          add_x = {2'b00, acc_q};
          add_y = m_q[0] ? {2'b00, sh_q} : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    is_div_d = is_div_q;
    neg_d    = neg_q;
    acc_d    = acc_q;
    sh_d     = sh_q;
    m_d      = m_q;
    unique case (state_q)
      M_IDLE: begin
        if (req_i.start) begin
          is_div_d = req_i.is_div;
          neg_d    = req_i.a[DataW-1] ^ req_i.b[DataW-1];
          sh_d     = req_i.a;
          m_d      = req_i.b;
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = req_i.is_div ? M_ABS_A : M_STEP;
        end
      end
      M_ABS_A: begin
        if (sh_q[DataW-1]) sh_d = sum[DataW-1:0];
        state_d = M_ABS_B;
      end
      M_ABS_B: begin
        if (m_q[DataW-1]) m_d = sum[DataW-1:0];
        state_d = M_STEP;
      end
      M_STEP: begin
        if (is_div_q) begin
          acc_d = ge ? sum[DataW-1:0] : rem_sh[DataW-1:0];
          sh_d  = {sh_q[DataW-2:0], ge};
        end else begin
          acc_d = sum[DataW-1:0];
          sh_d  = {sh_q[DataW-2:0], 1'b0};
          m_d   = {1'b0, m_q[DataW-1:1]};
        end
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(DataW - 1)) state_d = M_FIX;
      end
      M_FIX: begin
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_div_q <= is_div_d;
    neg_q    <= neg_d;
    acc_q    <= acc_d;
    sh_q     <= sh_d;
    m_q      <= m_d;
  end

  // Fix the quotient sign on the last cycle.
  always_comb begin
    rsp_o.done = (state_q == M_FIX);
    if (!is_div_q) begin
      rsp_o.result = acc_q;
    end else if (neg_q) begin
      rsp_o.result = sum[DataW-1:0];
    end else begin
      rsp_o.result = sh_q;
    end
  end

endmodule

>>> rtl/stack_machine_alu.sv
// ----------------------------------------------------------------------------
// stack_machine_alu
// Executes one stack-machine instruction per input word on a stack of signed
// 32-bit values held in RAM, with a shared iterative multiply/divide unit.
//
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+-----------------------
//   in      | into      | in_valid_i / in_stall_o  | sma_in_t  (cmd, value)
//   out     | out of    | out_valid_o / out_stall_i| sma_out_t (printed,
//           |           |                          |   out_value, status)
//
// After decode, ret, push, underflow, overflow and the unused opcode go to the
// done state; pop reads the top entry, add/sub and divide by zero read both
// operands, and mul and div then run the mul/div unit, which produces one
// result bit per cycle on its adder; the stack RAM has one read port, so the
// two operands are read in turn.
// Reset clears the stack level and the control state; the stack RAM is not
// cleared and needs no clearing pass. A new word is taken as soon as the
// sequencer is idle, even while the previous result is still stalled in the
// output register; the sequencer then holds its finished result until the
// output register frees up.
// ----------------------------------------------------------------------------
module stack_machine_alu #(
  parameter int STACK_DEPTH = sma_pkg::StackDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sma_pkg::sma_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sma_pkg::sma_out_t out_data_o
);
  import sma_pkg::*;

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int LW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_POP,
    S_RD_TOP,
    S_RD_NXT,
    S_EXEC,
    S_DONE
  } seq_state_e;

  seq_state_e       state_q, state_d;
  logic [LW-1:0]    level_q, level_d;
  logic [CmdW-1:0]  cmd_q, cmd_d;
  logic [DataW-1:0] val_q, val_d;
  logic [DataW-1:0] top_q, top_d;
  sma_out_t         res_q, res_d;
  sma_out_t         out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [LW-1:0]    lvl_m1, lvl_m2;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_wdata, ram_rdata;
  md_req_t          md_req;
  md_rsp_t          md_rsp;
  logic             out_load;

  assign lvl_m1 = level_q - LW'(1);
  assign lvl_m2 = level_q - LW'(2);

  sma_ram #(
    .WIDTH (DataW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sma_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  // Output register takes the finished result when it is empty or draining.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    level_d   = level_q;
    cmd_d     = cmd_q;
    val_d     = val_q;
    top_d     = top_q;
    res_d     = res_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    md_req    = '{start: 1'b0, is_div: (cmd_q == CMD_DIV), a: top_q, b: ram_rdata};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = in_data_i.cmd;
          val_d   = in_data_i.push_value;
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        res_d   = '{printed: 1'b0, out_value: '0, status: ST_OK};
        state_d = S_DONE;
        unique case (cmd_q) inside
          CMD_RET: res_d.status = ST_RET;
          CMD_PUSH: begin
            if (level_q == LW'(STACK_DEPTH)) begin
              res_d.status = ST_OVER;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = level_q[AW-1:0];
              ram_wdata = val_q;
              level_d   = level_q + LW'(1);
            end
          end
          CMD_POP: begin
            if (level_q == '0) begin
              res_d.status = ST_UNDER;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = lvl_m1[AW-1:0];
              state_d   = S_RD_POP;
            end
          end
          CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
            if (level_q < LW'(2)) begin
              res_d.status = ST_UNDER;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = lvl_m1[AW-1:0];
              state_d   = S_RD_TOP;
            end
          end
          default: begin
            // Unused opcode: no operation.
          end
        endcase
      end

      S_RD_POP: begin
        res_d.printed   = 1'b1;
        res_d.out_value = ram_rdata;
        level_d         = lvl_m1;
        state_d         = S_DONE;
      end

      S_RD_TOP: begin
        // Latch the first operand, fetch the second.
        top_d     = ram_rdata;
        ram_re    = 1'b1;
        ram_raddr = lvl_m2[AW-1:0];
        state_d   = S_RD_NXT;
      end

      S_RD_NXT: begin
        state_d = S_DONE;
        unique case (cmd_q) inside
          CMD_ADD, CMD_SUB: begin
            ram_we    = 1'b1;
            ram_waddr = lvl_m2[AW-1:0];
            ram_wdata = (cmd_q == CMD_ADD) ? (top_q + ram_rdata) : (top_q - ram_rdata);
            level_d   = lvl_m1;
          end
          CMD_DIV: begin
            if (ram_rdata == '0) begin
              res_d.status = ST_DIVZ;
            end else begin
              md_req.start = 1'b1;
              state_d      = S_EXEC;
            end
          end
          default: begin
            md_req.start = 1'b1;
            state_d      = S_EXEC;
          end
        endcase
      end

      S_EXEC: begin
        // Wait for the mul/div unit, then replace the second operand.
        if (md_rsp.done) begin
          ram_we    = 1'b1;
          ram_waddr = lvl_m2[AW-1:0];
          ram_wdata = md_rsp.result;
          level_d   = lvl_m1;
          state_d   = S_DONE;
        end
      end

      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Output register.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      level_q     <= '0;
      out_valid_q <= 1'b0;
      cmd_q       <= '0;
      val_q       <= '0;
      top_q       <= '0;
      res_q       <= '0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      level_q     <= level_d;
      out_valid_q <= out_valid_d;
      cmd_q       <= cmd_d;
      val_q       <= val_d;
      top_q       <= top_d;
      res_q       <= res_d;
      out_q       <= out_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Stack level stays within the RAM.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");

  // RAM writes land at or below the current stack level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (LW'(ram_waddr) <= level_q))
    else $error("stack write above level");

  // The mul/div unit only finishes while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_rsp.done |-> (state_q == S_EXEC))
    else $error("mul/div done outside of execute");

  // After a load, the output register holds a valid result and the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (state_q == S_IDLE)))
    else $error("result load lost");

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for stack_machine_alu. Runs a directed table of corner
// words (empty stack, divide by zero, wrapping arithmetic, unused opcode),
// then random instruction streams and one fill-to-overflow pass.
// An in-bench stack model predicts every result word. Both handshake sides
// idle at random.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sma_pkg::*;

  localparam int          StackDepth = StackDepthDef;
  localparam int          CycleLimit = 1000000;
  localparam int          LongHold   = 300;
  localparam int          DrainWait  = 60;
  localparam int          NumProbes  = 24;
  localparam logic [2:0]  CmdUnused  = 3'd7;
  localparam logic [31:0] MinWord    = 32'h8000_0000;
  localparam logic [31:0] MaxWord    = 32'h7fff_ffff;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  sma_in_t  in_data_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  sma_out_t out_data_o;

  stack_machine_alu dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Stack model: mirrors the block's stack as words are accepted.
  logic [31:0] stack_mem [StackDepth];
  int          stack_level = 0;

  // Result words still owed by the block, oldest first.
  sma_out_t owed_results [$];

  int  mismatches  = 0;
  int  cycle_count = 0;
  int  send_calm   = 0;
  int  recv_calm   = 0;
  bit  hold_off_req = 1'b0;

  // One directed row: the word, and the result where it is obvious.
  typedef struct {
    logic [2:0]  cmd;
    logic [31:0] value;
    bit          known;
    sma_out_t    result;
  } probe_t;

  probe_t probes [NumProbes] = '{
    '{CMD_POP,   32'h0,         1'b1, '{1'b0, 32'h0, ST_UNDER}},  // pop on empty
    '{CMD_ADD,   32'h0,         1'b1, '{1'b0, 32'h0, ST_UNDER}},  // add on empty
    '{CMD_RET,   32'hffff_ffff, 1'b1, '{1'b0, 32'h0, ST_RET}},
    '{CmdUnused, 32'h0,         1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_PUSH,  32'h0,         1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_DIV,   32'h0,         1'b1, '{1'b0, 32'h0, ST_UNDER}},  // one entry only
    '{CMD_PUSH,  32'd5,         1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_DIV,   32'h0,         1'b1, '{1'b0, 32'h0, ST_DIVZ}},   // 5 / 0
    '{CMD_POP,   32'h1234_5678, 1'b1, '{1'b1, 32'd5, ST_OK}},     // value ignored
    '{CMD_POP,   32'h0,         1'b1, '{1'b1, 32'h0, ST_OK}},
    '{CMD_PUSH,  32'hffff_ffff, 1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_PUSH,  MinWord,       1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_DIV,   32'h0,         1'b0, '0},                        // min / -1 wraps
    '{CMD_POP,   32'h0,         1'b1, '{1'b1, MinWord, ST_OK}},
    '{CMD_PUSH,  32'd3,         1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_PUSH,  32'hffff_fff9, 1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_DIV,   32'h0,         1'b0, '0},                        // -7 / 3 toward zero
    '{CMD_PUSH,  MaxWord,       1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_PUSH,  MaxWord,       1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_ADD,   32'h0,         1'b0, '0},                        // max + max wraps
    '{CMD_MUL,   32'h0,         1'b0, '0},
    '{CMD_PUSH,  MinWord,       1'b1, '{1'b0, 32'h0, ST_OK}},
    '{CMD_SUB,   32'h0,         1'b0, '0},                        // min - 4 wraps
    '{CMD_POP,   32'h0,         1'b0, '0}
  };

  // Execute one word on the stack model and return its result word.
  function automatic sma_out_t execute_word(input sma_in_t w);
    sma_out_t    r;
    logic [31:0] top, nxt, res, mag_a, mag_b, quo;
    r = '0;
    r.status = ST_OK;
    case (w.cmd)
      CMD_RET: r.status = ST_RET;
      CMD_PUSH: begin
        if (stack_level >= StackDepth) begin
          r.status = ST_OVER;
        end else begin
          stack_mem[stack_level] = w.push_value;
          stack_level++;
        end
      end
      CMD_POP: begin
        if (stack_level == 0) begin
          r.status = ST_UNDER;
        end else begin
          stack_level--;
          r.printed   = 1'b1;
          r.out_value = stack_mem[stack_level];
        end
      end
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
        if (stack_level < 2) begin
          r.status = ST_UNDER;
        end else begin
          top = stack_mem[stack_level-1];
          nxt = stack_mem[stack_level-2];
          if (w.cmd == CMD_DIV && nxt == '0) begin
            r.status = ST_DIVZ;
          end else begin
            case (w.cmd)
              CMD_ADD: res = top + nxt;
              CMD_SUB: res = top - nxt;
              CMD_MUL: res = top * nxt;
              default: begin
                // divide magnitudes, then fix the sign: truncates toward zero
                mag_a = top[31] ? -top : top;
                mag_b = nxt[31] ? -nxt : nxt;
                quo   = mag_a / mag_b;
                res   = (top[31] ^ nxt[31]) ? -quo : quo;
              end
            endcase
            stack_level--;
            stack_mem[stack_level-1] = res;
          end
        end
      end
      default: ;  // unused opcode: no operation
    endcase
    return r;
  endfunction

  // Random wait length for one word, with calm stretches of no idling.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // Operand values: lean on the corners, otherwise anything.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return MinWord;
      2: return MaxWord;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed programs (enough pushes to feed the arithmetic),
  // with some raw noise mixed in.
  function automatic sma_in_t next_random_word();
    sma_in_t w;
    int      pick;
    w.push_value = pick_value();
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      w.cmd = 3'($urandom_range(0, 7));
    end else if (stack_level < 2 || (pick < 40 && stack_level < 24)) begin
      w.cmd = CMD_PUSH;
    end else if (pick < 52) begin
      w.cmd = CMD_POP;
    end else if (pick < 55) begin
      w.cmd = CMD_RET;
    end else begin
      w.cmd = 3'($urandom_range(CMD_ADD, CMD_DIV));
    end
    return w;
  endfunction

  // Offer one word after a random gap; hold it until accepted, then log the
  // owed result (typed-in when known, else predicted).
  task automatic send_word(input sma_in_t w, input bit known, input sma_out_t typed);
    int       gap;
    sma_out_t predicted;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = execute_word(w);
    owed_results.push_back(known ? typed : predicted);
  endtask

  task automatic send_cmd(input logic [2:0] cmd);
    sma_in_t w;
    w.cmd        = cmd;
    w.push_value = pick_value();
    send_word(w, 1'b0, '0);
  endtask

  // Sender: reset, directed table, random streams, one fill-to-full pass.
  initial begin : word_source
    sma_in_t w;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      w.cmd        = probes[i].cmd;
      w.push_value = probes[i].value;
      send_word(w, probes[i].known, probes[i].result);
    end

    for (int n = 0; n < 850; n++) begin
      if (n == 100) begin
        // stall the result side for a long stretch and keep offering words
        hold_off_req = 1'b1;
        send_calm    = 40;
      end
      if (n == 500) begin
        // fill the stack, overflow it, then drain past empty
        while (stack_level < StackDepth) send_cmd(CMD_PUSH);
        repeat (3) send_cmd(CMD_PUSH);
        send_cmd(CMD_MUL);
        send_cmd(CMD_PUSH);
        send_cmd(CMD_PUSH);
        while (stack_level > 0) send_cmd(CMD_POP);
        send_cmd(CMD_POP);
      end
      send_word(next_random_word(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Receiver: stall for a random count after each accepted result word.
  initial begin : result_sink
    int hold;
    bit held_long;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req && !held_long) begin
        hold      = LongHold;
        held_long = 1'b1;
      end else begin
        hold = draw_wait(recv_calm);
      end
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Compare each accepted result word with the oldest owed one.
  always @(posedge clk_i) begin
    sma_out_t exp_word;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result word, expected none, got %h", $time, out_data_o);
      end else begin
        exp_word = owed_results.pop_front();
        if (out_data_o.printed !== exp_word.printed) begin
          mismatches++;
          $display("%0t: printed expected %0b got %0b",
                   $time, exp_word.printed, out_data_o.printed);
        end
        if (out_data_o.out_value !== exp_word.out_value) begin
          mismatches++;
          $display("%0t: out_value expected %h got %h",
                   $time, exp_word.out_value, out_data_o.out_value);
        end
        if (out_data_o.status !== exp_word.status) begin
          mismatches++;
          $display("%0t: status expected %0d got %0d",
                   $time, exp_word.status, out_data_o.status);
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule

>>> sim.f
rtl/sma_pkg.sv
rtl/sma_ram.sv
rtl/sma_muldiv.sv
rtl/stack_machine_alu.sv
tb/testbench.sv
